// ----- src/hgef_pkg.sv -----
// hgef_pkg: shared types, codes and constants for the gateway entry filter
// used by the channel interfaces and every module of the filter
// no dependencies
package hgef_pkg;

  localparam int ADDR_BITS       = 32;
  localparam int ADDR_BYTES      = ADDR_BITS / 8;
  localparam int FIXED_HDR_BYTES = 8;
  localparam int HDR_BYTES       = FIXED_HDR_BYTES + ADDR_BYTES;
  localparam int ENTRY_BYTES     = 2 * ADDR_BYTES;
  localparam int ENTRY_SHIFT     = $clog2(ENTRY_BYTES);

  localparam int NUM_ORIGINS_DEF = 4;
  localparam int NUM_ORIGINS_MAX = 4;

  localparam int KIND_BITS    = 8;
  localparam int LEN_BITS     = 16;
  localparam int COUNT_BITS   = 3;
  localparam int ENTRIES_BITS = 13;
  localparam int STATUS_BITS  = 3;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALLOWLIST_MODE     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_COUNT       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_ADDR_0      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ANNOUNCE_TYPE_CODE = 3'd6;

  localparam logic [KIND_BITS-1:0] ANNOUNCE_TYPE_RESET = 8'd4;

  // item kinds
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_ENTRY  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_FORWARD = 3'd0,
    ST_FOLLOW  = 3'd1,
    ST_DROP    = 3'd2,
    ST_KEPT    = 3'd3,
    ST_REMOVED = 3'd4,
    ST_STRAY   = 3'd5
  } status_t;

  typedef struct packed {
    logic                  allowlist_mode;
    logic [COUNT_BITS-1:0] origin_count;
    logic [KIND_BITS-1:0]  announce_type_code;
  } cfg_t;

  typedef struct packed {
    logic                 operation;
    logic [KIND_BITS-1:0] msg_kind;
    logic [LEN_BITS-1:0]  msg_length;
    logic [ADDR_BITS-1:0] sender_addr;
    logic [ADDR_BITS-1:0] net_prefix;
    logic [ADDR_BITS-1:0] net_mask;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [LEN_BITS-1:0] new_length;
    logic                last;
    logic                drop_whole;
  } result_t;

endpackage

// ----- src/hgef_req_if.sv -----
// hgef_req_if: request channel of the gateway entry filter (valid/ready)
// depends on hgef_pkg for field widths
interface hgef_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [hgef_pkg::KIND_BITS-1:0] msg_kind;
  logic [hgef_pkg::LEN_BITS-1:0]  msg_length;
  logic [hgef_pkg::ADDR_BITS-1:0] sender_addr;
  logic [hgef_pkg::ADDR_BITS-1:0] net_prefix;
  logic [hgef_pkg::ADDR_BITS-1:0] net_mask;

  modport source (
    output valid, operation, msg_kind, msg_length, sender_addr, net_prefix, net_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, msg_kind, msg_length, sender_addr, net_prefix, net_mask,
    output ready
  );
endinterface

// ----- src/hgef_res_if.sv -----
// hgef_res_if: result channel of the gateway entry filter (valid/ready)
// depends on hgef_pkg for field widths
interface hgef_res_if;
  logic                            valid;
  logic                            ready;
  logic [hgef_pkg::STATUS_BITS-1:0] status;
  logic [hgef_pkg::LEN_BITS-1:0]    new_length;
  logic                            last;
  logic                            drop_whole;

  modport source (
    output valid, status, new_length, last, drop_whole,
    input  ready
  );
  modport sink (
    input  valid, status, new_length, last, drop_whole,
    output ready
  );
endinterface

// ----- src/hgef_cfg_regs.sv -----
// hgef_cfg_regs: configuration register file of the gateway entry filter
// depends on hgef_pkg
module hgef_cfg_regs #(
  parameter int NUM_ORIGINS = hgef_pkg::NUM_ORIGINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [hgef_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [hgef_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output hgef_pkg::cfg_t                      cfg,
  output logic [hgef_pkg::ADDR_BITS-1:0]      origin_addr [NUM_ORIGINS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.allowlist_mode     <= 1'b0;
      cfg.origin_count       <= '0;
      cfg.announce_type_code <= hgef_pkg::ANNOUNCE_TYPE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        hgef_pkg::CFG_ALLOWLIST_MODE: begin
          cfg.allowlist_mode <= wr_data[0];
        end
        hgef_pkg::CFG_ORIGIN_COUNT: begin
          cfg.origin_count <= wr_data[hgef_pkg::COUNT_BITS-1:0];
        end
        hgef_pkg::CFG_ANNOUNCE_TYPE_CODE: begin
          cfg.announce_type_code <= wr_data[hgef_pkg::KIND_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // one address register per list slot
  for (genvar i = 0; i < NUM_ORIGINS; i++) begin : g_addr
    localparam logic [hgef_pkg::CFG_INDEX_BITS-1:0] SLOT_INDEX =
      hgef_pkg::CFG_INDEX_BITS'(int'(hgef_pkg::CFG_ORIGIN_ADDR_0) + i);
    always_ff @(posedge clk) begin
      if (rst) begin
        origin_addr[i] <= '0;
      end else if (wr_en && wr_index == SLOT_INDEX) begin
        origin_addr[i] <= wr_data[hgef_pkg::ADDR_BITS-1:0];
      end
    end
  end

endmodule

// ----- src/hgef_origin_match.sv -----
// hgef_origin_match: compares an originator with the configured list
// depends on hgef_pkg
module hgef_origin_match #(
  parameter int NUM_ORIGINS = hgef_pkg::NUM_ORIGINS_DEF
) (
  input  hgef_pkg::cfg_t                 cfg,
  input  logic [hgef_pkg::ADDR_BITS-1:0] origin_addr [NUM_ORIGINS],
  input  logic [hgef_pkg::ADDR_BITS-1:0] sender_addr,
  output logic                           filtered
);

  logic [NUM_ORIGINS-1:0] hit;

  // slots at or above the count never match; an empty list leaves the mode bit
  for (genvar i = 0; i < NUM_ORIGINS; i++) begin : g_cmp
    assign hit[i] = (hgef_pkg::COUNT_BITS'(i) < cfg.origin_count) &&
                    (origin_addr[i] == sender_addr);
  end

  assign filtered = cfg.allowlist_mode ^ (|hit);

endmodule

// ----- src/hgef_msg_ctrl.sv -----
// hgef_msg_ctrl: per-message state and result decision of the entry filter
// depends on hgef_pkg
module hgef_msg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  hgef_pkg::cfg_t      cfg,
  input  hgef_pkg::item_t     item,
  input  logic                filtered,
  input  logic                commit,
  output hgef_pkg::result_t   result
);

  logic                                filtering_active, filtering_active_next;
  logic [hgef_pkg::ENTRIES_BITS-1:0]   entries_left, entries_left_next;
  logic [hgef_pkg::LEN_BITS-1:0]       current_length, current_length_next;
  logic                                kept_any, kept_any_next;

  logic [hgef_pkg::LEN_BITS-1:0]       body;
  logic                                len_ok;
  logic                                is_default;
  logic [hgef_pkg::ENTRIES_BITS-1:0]   left_dec;

  assign body   = item.msg_length - hgef_pkg::LEN_BITS'(hgef_pkg::HDR_BYTES);
  assign len_ok = (item.msg_length >= hgef_pkg::LEN_BITS'(hgef_pkg::HDR_BYTES)) &&
                  (body[hgef_pkg::ENTRY_SHIFT-1:0] == '0);
  assign is_default = (item.net_prefix == '0) && (item.net_mask == '0);
  assign left_dec   = entries_left - hgef_pkg::ENTRIES_BITS'(1);

  always_comb begin
    filtering_active_next = filtering_active;
    entries_left_next     = entries_left;
    current_length_next   = current_length;
    kept_any_next         = kept_any;
    result.status         = hgef_pkg::ST_STRAY;
    result.new_length     = current_length;
    result.last           = 1'b0;
    result.drop_whole     = 1'b0;

    if (item.operation == hgef_pkg::OP_HEADER) begin
      // a header always closes whatever was open
      filtering_active_next = 1'b0;
      entries_left_next     = '0;
      kept_any_next         = 1'b0;
      current_length_next   = item.msg_length;
      result.new_length     = item.msg_length;
      result.last           = 1'b1;
      if (item.msg_kind != cfg.announce_type_code) begin
        result.status     = hgef_pkg::ST_DROP;
        result.drop_whole = 1'b1;
      end else if (!filtered) begin
        result.status = hgef_pkg::ST_FORWARD;
      end else if (!len_ok) begin
        result.status     = hgef_pkg::ST_DROP;
        result.drop_whole = 1'b1;
      end else if (body == '0) begin
        result.status = hgef_pkg::ST_FORWARD;
      end else begin
        result.status         = hgef_pkg::ST_FOLLOW;
        result.last           = 1'b0;
        entries_left_next     = hgef_pkg::ENTRIES_BITS'(body >> hgef_pkg::ENTRY_SHIFT);
        filtering_active_next = 1'b1;
      end
    end else if (filtering_active && entries_left != '0) begin
      entries_left_next = left_dec;
      if (is_default) begin
        current_length_next = current_length - hgef_pkg::LEN_BITS'(hgef_pkg::ENTRY_BYTES);
        result.status       = hgef_pkg::ST_REMOVED;
      end else begin
        kept_any_next = 1'b1;
        result.status = hgef_pkg::ST_KEPT;
      end
      result.new_length = current_length_next;
      if (left_dec == '0) begin
        result.last           = 1'b1;
        result.drop_whole     = !kept_any_next;
        filtering_active_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtering_active <= 1'b0;
      entries_left     <= '0;
      current_length   <= '0;
      kept_any         <= 1'b0;
    end else if (commit) begin
      filtering_active <= filtering_active_next;
      entries_left     <= entries_left_next;
      current_length   <= current_length_next;
      kept_any         <= kept_any_next;
    end
  end

endmodule

// ----- src/hna_gateway_entry_filter_unit.sv -----
// hna_gateway_entry_filter_unit: top level of the gateway entry filter
// a request passes through the input register and then the result register;
// throughput one request per cycle while the result side is ready
// reset (rst, synchronous, active high) empties both registers, closes any open
// message and returns configuration to defaults (announcement type 4, empty list)
// depends on hgef_pkg, hgef_req_if, hgef_res_if and the hgef_* submodules
module hna_gateway_entry_filter_unit #(
  parameter int NUM_ORIGINS = hgef_pkg::NUM_ORIGINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  hgef_req_if.sink                            req,
  hgef_res_if.source                          res,
  input  logic                                wr_en,
  input  logic [hgef_pkg::CFG_INDEX_BITS-1:0] wr_index,
  input  logic [hgef_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  // configuration and originator list
  hgef_pkg::cfg_t                 cfg;
  logic [hgef_pkg::ADDR_BITS-1:0] origin_addr [NUM_ORIGINS];

  // input register stage
  logic            in_valid;
  hgef_pkg::item_t in_item;

  // result register stage
  logic              out_valid;
  hgef_pkg::result_t out_res;
  hgef_pkg::result_t res_next;

  logic out_load;   // result register can take a new value
  logic in_adv;     // input register moves into the result register
  logic filtered;

  hgef_cfg_regs #(
    .NUM_ORIGINS (NUM_ORIGINS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .cfg         (cfg),
    .origin_addr (origin_addr)
  );

  // list compare runs on the registered header
  hgef_origin_match #(
    .NUM_ORIGINS (NUM_ORIGINS)
  ) u_match (
    .cfg         (cfg),
    .origin_addr (origin_addr),
    .sender_addr (in_item.sender_addr),
    .filtered    (filtered)
  );

  // message state only moves when the item actually reaches the result register
  hgef_msg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (in_item),
    .filtered (filtered),
    .commit   (in_adv),
    .result   (res_next)
  );

  // handshake: the result register frees up when empty or being taken,
  // so a new request is taken while a finished result still waits only if the input register is empty
  assign out_load  = !out_valid || res.ready;
  assign in_adv    = in_valid && out_load;
  assign req.ready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  // payload of a request, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.operation   <= req.operation;
      in_item.msg_kind    <= req.msg_kind;
      in_item.msg_length  <= req.msg_length;
      in_item.sender_addr <= req.sender_addr;
      in_item.net_prefix  <= req.net_prefix;
      in_item.net_mask    <= req.net_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_res <= res_next;
    end
  end

  // result channel
  assign res.valid      = out_valid;
  assign res.status     = out_res.status;
  assign res.new_length = out_res.new_length;
  assign res.last       = out_res.last;
  assign res.drop_whole = out_res.drop_whole;

endmodule

// ----- tb/hgef_filter_checker.sv -----
`timescale 1ns / 100ps
// hgef_filter_checker: watches the request, result and register ports of the gateway
// entry filter, predicts each result and compares it with what the block returns
// depends on hgef_pkg, hgef_req_if and hgef_res_if
module hgef_filter_checker
  import hgef_pkg::*;
#(
  parameter int NUM_ORIGINS = NUM_ORIGINS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  hgef_req_if                       req,
  hgef_res_if                       res,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output int                        pending = 0,
  output int                        fail_count = 0
);

  // register copy
  logic                    allow_mode;
  logic [COUNT_BITS-1:0]   list_count;
  logic [ADDR_BITS-1:0]    list_addr [NUM_ORIGINS_MAX];
  logic [KIND_BITS-1:0]    announce_kind;

  // open message tracking
  logic                    msg_open;
  logic [ENTRIES_BITS-1:0] entries_rem;
  logic [LEN_BITS-1:0]     cur_len;
  logic                    any_kept;

  result_t expected_q[$];
  int      errors = 0;

  function automatic result_t pack_result(input status_t st, input logic [LEN_BITS-1:0] len,
                                          input logic lst, input logic whole);
    result_t r;
    r.status     = st;
    r.new_length = len;
    r.last       = lst;
    r.drop_whole = whole;
    return r;
  endfunction

  function automatic logic sender_filtered(input logic [ADDR_BITS-1:0] sender);
    int   n;
    logic hit;
    n   = (list_count > NUM_ORIGINS) ? NUM_ORIGINS : int'(list_count);
    hit = 1'b0;
    if (list_count == '0) return allow_mode;
    for (int i = 0; i < n; i++)
      if (list_addr[i] == sender) hit = 1'b1;
    return allow_mode ? !hit : hit;
  endfunction

  // advances the message state by one request and returns its result
  function automatic result_t filter_step(input item_t it);
    status_t st;
    logic    lst;
    if (it.operation == OP_HEADER) begin
      msg_open    = 1'b0;
      entries_rem = '0;
      any_kept    = 1'b0;
      cur_len     = it.msg_length;
      if (it.msg_kind != announce_kind)
        return pack_result(ST_DROP, it.msg_length, 1'b1, 1'b1);
      if (!sender_filtered(it.sender_addr))
        return pack_result(ST_FORWARD, it.msg_length, 1'b1, 1'b0);
      if (it.msg_length < HDR_BYTES || ((it.msg_length - HDR_BYTES) % ENTRY_BYTES) != 0)
        return pack_result(ST_DROP, it.msg_length, 1'b1, 1'b1);
      if (it.msg_length == HDR_BYTES)
        return pack_result(ST_FORWARD, it.msg_length, 1'b1, 1'b0);
      entries_rem = ENTRIES_BITS'((it.msg_length - HDR_BYTES) / ENTRY_BYTES);
      msg_open    = 1'b1;
      return pack_result(ST_FOLLOW, it.msg_length, 1'b0, 1'b0);
    end
    if (!msg_open || entries_rem == '0)
      return pack_result(ST_STRAY, cur_len, 1'b0, 1'b0);
    entries_rem = entries_rem - 1'b1;
    if (it.net_prefix == '0 && it.net_mask == '0) begin
      cur_len = cur_len - LEN_BITS'(ENTRY_BYTES);
      st      = ST_REMOVED;
    end else begin
      any_kept = 1'b1;
      st       = ST_KEPT;
    end
    lst = (entries_rem == '0);
    if (lst) msg_open = 1'b0;
    return pack_result(st, cur_len, lst, lst && !any_kept);
  endfunction

  always @(posedge clk) begin
    result_t want;
    item_t   it;
    if (rst) begin
      allow_mode    = 1'b0;
      list_count    = '0;
      for (int i = 0; i < NUM_ORIGINS_MAX; i++) list_addr[i] = '0;
      announce_kind = ANNOUNCE_TYPE_RESET;
      msg_open      = 1'b0;
      entries_rem   = '0;
      cur_len       = '0;
      any_kept      = 1'b0;
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: status %0d new_length %0d",
                 res.status, res.new_length);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (res.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res.status);
            errors++;
          end
          if (res.new_length !== want.new_length) begin
            $error("new_length: expected %0d, actual %0d", want.new_length, res.new_length);
            errors++;
          end
          if (res.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, res.last);
            errors++;
          end
          if (res.drop_whole !== want.drop_whole) begin
            $error("drop_whole: expected %0d, actual %0d", want.drop_whole, res.drop_whole);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        it.operation   = req.operation;
        it.msg_kind    = req.msg_kind;
        it.msg_length  = req.msg_length;
        it.sender_addr = req.sender_addr;
        it.net_prefix  = req.net_prefix;
        it.net_mask    = req.net_mask;
        expected_q.push_back(filter_step(it));
      end
      if (wr_en) begin
        case (wr_index)
          CFG_ALLOWLIST_MODE:     allow_mode    = wr_data[0];
          CFG_ORIGIN_COUNT:       list_count    = wr_data[COUNT_BITS-1:0];
          CFG_ANNOUNCE_TYPE_CODE: announce_kind = wr_data[KIND_BITS-1:0];
          default: begin
            if (wr_index >= CFG_ORIGIN_ADDR_0 &&
                int'(wr_index) < int'(CFG_ORIGIN_ADDR_0) + NUM_ORIGINS_MAX)
              list_addr[wr_index - CFG_ORIGIN_ADDR_0] = wr_data;
          end
        endcase
      end
    end
    pending    <= expected_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/hna_gateway_entry_filter_unit_test.sv -----
`timescale 1ns / 100ps
// hna_gateway_entry_filter_unit_test: stimulus and verdict for the gateway entry filter
// directed corner requests, then six register settings with random message traffic
// depends on hgef_pkg, the hgef channel interfaces, the filter and hgef_filter_checker
module hna_gateway_entry_filter_unit_test;
  import hgef_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // far above the slowest correct run
  localparam int PHASE_ITEMS = 270;     // requests per register setting
  localparam int LONG_HOLD   = 200;     // cycles of the long result back-pressure

  logic                      clk;
  logic                      rst;
  logic                      wr_en;
  logic [CFG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  hgef_req_if req_ch ();
  hgef_res_if res_ch ();

  int   pending;
  int   fail_count;
  int   cycle_count   = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   phase_items   = 0;
  logic hold_wanted   = 1'b0;

  // copy of what was last written, used to aim senders at the list
  logic [KIND_BITS-1:0] kind_now;
  logic [ADDR_BITS-1:0] list_now [NUM_ORIGINS_MAX];

  hna_gateway_entry_filter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  hgef_filter_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_wanted && !hold_done) begin
        res_ch.ready <= 1'b0;
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // one request: optional idle cycles, then hold valid until taken
  task automatic drive_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.operation   <= it.operation;
    req_ch.msg_kind    <= it.msg_kind;
    req_ch.msg_length  <= it.msg_length;
    req_ch.sender_addr <= it.sender_addr;
    req_ch.net_prefix  <= it.net_prefix;
    req_ch.net_mask    <= it.net_mask;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    phase_items++;
  endtask

  // header request; entry fields carry junk the block must ignore
  task automatic send_header(input logic [KIND_BITS-1:0] kind,
                             input logic [LEN_BITS-1:0]  len,
                             input logic [ADDR_BITS-1:0] sender);
    item_t it;
    it.operation   = OP_HEADER;
    it.msg_kind    = kind;
    it.msg_length  = len;
    it.sender_addr = sender;
    it.net_prefix  = $urandom;
    it.net_mask    = $urandom;
    drive_item(it);
  endtask

  // entry request; header fields carry junk
  task automatic send_entry(input logic [ADDR_BITS-1:0] prefix,
                            input logic [ADDR_BITS-1:0] mask);
    item_t it;
    it.operation   = OP_ENTRY;
    it.msg_kind    = KIND_BITS'($urandom);
    it.msg_length  = LEN_BITS'($urandom);
    it.sender_addr = $urandom;
    it.net_prefix  = prefix;
    it.net_mask    = mask;
    drive_item(it);
  endtask

  // default routes are common so removals and whole-message drops happen often
  task automatic send_random_entry();
    int r;
    r = $urandom_range(99);
    if (r < 30)      send_entry('0, '0);
    else if (r < 40) send_entry('0, $urandom);
    else if (r < 50) send_entry($urandom, '0);
    else             send_entry($urandom, $urandom);
  endtask

  // well-formed message with random content; some cut short, some with a stray tail
  task automatic send_message();
    int r;
    int n;
    int k;
    logic [ADDR_BITS-1:0] sender;
    logic [KIND_BITS-1:0] kind;
    r = $urandom_range(99);
    if (r < 70)      n = $urandom_range(6, 1);
    else if (r < 82) n = 0;
    else if (r < 96) n = $urandom_range(40, 7);
    else             n = $urandom_range(8190, 41);
    sender = ($urandom_range(99) < 60) ? list_now[$urandom_range(NUM_ORIGINS_MAX - 1)]
                                       : ADDR_BITS'($urandom);
    kind   = ($urandom_range(99) < 90) ? kind_now : KIND_BITS'($urandom);
    // huge messages are only started, then abandoned by the next header
    k = (n > 40) ? $urandom_range(20, 1) : n;
    r = $urandom_range(99);
    if (r < 8 && k > 1) k = $urandom_range(k - 1, 1);
    else if (r < 14)    k = k + 1;
    send_header(kind, LEN_BITS'(HDR_BYTES + ENTRY_BYTES * n), sender);
    repeat (k) send_random_entry();
  endtask

  // random headers, bad sizes and entries outside a message
  task automatic send_noise();
    int r;
    logic [LEN_BITS-1:0] len;
    r = $urandom_range(99);
    if (r < 35) begin
      send_header(KIND_BITS'($urandom), LEN_BITS'($urandom), $urandom);
    end else if (r < 65) begin
      if ($urandom_range(1) == 0) len = LEN_BITS'($urandom_range(HDR_BYTES - 1, 0));
      else len = LEN_BITS'(HDR_BYTES + ENTRY_BYTES * $urandom_range(20, 0)
                           + $urandom_range(ENTRY_BYTES - 1, 1));
      send_header(kind_now, len, list_now[$urandom_range(NUM_ORIGINS_MAX - 1)]);
    end else begin
      send_random_entry();
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic finish_batch();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // writes every register; list_now must already hold the addresses
  task automatic load_setup(input logic mode, input logic [COUNT_BITS-1:0] count,
                            input logic [KIND_BITS-1:0] kind);
    kind_now = kind;
    wr_en    <= 1'b1;
    wr_index <= CFG_ALLOWLIST_MODE;
    wr_data  <= CFG_DATA_BITS'(mode);
    @(posedge clk);
    wr_index <= CFG_ORIGIN_COUNT;
    wr_data  <= CFG_DATA_BITS'(count);
    @(posedge clk);
    for (int i = 0; i < NUM_ORIGINS_MAX; i++) begin
      wr_index <= CFG_ORIGIN_ADDR_0 + CFG_INDEX_BITS'(i);
      wr_data  <= list_now[i];
      @(posedge clk);
    end
    wr_index <= CFG_ANNOUNCE_TYPE_CODE;
    wr_data  <= CFG_DATA_BITS'(kind);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  initial begin
    // known values on every input from time zero
    rst                <= 1'b1;
    wr_en              <= 1'b0;
    wr_index           <= '0;
    wr_data            <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_HEADER;
    req_ch.msg_kind    <= '0;
    req_ch.msg_length  <= '0;
    req_ch.sender_addr <= '0;
    req_ch.net_prefix  <= '0;
    req_ch.net_mask    <= '0;
    kind_now = ANNOUNCE_TYPE_RESET;
    for (int i = 0; i < NUM_ORIGINS_MAX; i++) list_now[i] = '0;
    send_idle_pct = 8;
    recv_idle_pct = 82;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty list, no allowlist, so announcements pass untouched
    send_header(ANNOUNCE_TYPE_RESET, 16'd20, '0);
    send_header(8'hFF, 16'hFFFF, 32'hFFFF_FFFF);  // wrong type
    send_entry('0, '0);                           // entry with nothing open
    finish_batch();

    // allowlist with an empty list filters every originator
    load_setup(1'b1, '0, ANNOUNCE_TYPE_RESET);
    send_header(kind_now, LEN_BITS'(HDR_BYTES), $urandom);      // no entries
    send_header(kind_now, LEN_BITS'(HDR_BYTES - 1), $urandom);  // below header size
    send_header(kind_now, 16'd0, $urandom);
    send_header(kind_now, LEN_BITS'(HDR_BYTES + 1), $urandom);  // partial entry
    send_header(kind_now, 16'hFFFF, $urandom);
    // largest legal size, abandoned after one entry by a new header
    send_header(kind_now, LEN_BITS'(HDR_BYTES + ENTRY_BYTES * 8190), $urandom);
    send_entry(32'd1, 32'd1);
    send_header(kind_now, LEN_BITS'(HDR_BYTES + ENTRY_BYTES * 2), $urandom);
    send_entry('0, '0);
    send_entry('0, '0);                           // all removed: whole drop
    send_header(kind_now, LEN_BITS'(HDR_BYTES + ENTRY_BYTES * 3), $urandom);
    send_entry('0, 32'hFFFF_FFFF);
    send_entry(32'hFFFF_FFFF, '0);
    send_entry('0, '0);
    send_entry($urandom, $urandom);               // after the message closed
    finish_batch();

    // oversized count saturates to the list depth, type code zero
    list_now[0] = 32'hFFFF_FFFF;
    list_now[1] = '0;
    list_now[2] = $urandom;
    list_now[3] = 32'h8000_0000;
    load_setup(1'b0, 3'd7, 8'd0);
    send_header(8'd0, LEN_BITS'(HDR_BYTES + ENTRY_BYTES), 32'hFFFF_FFFF);
    send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(8'd0, LEN_BITS'(HDR_BYTES + ENTRY_BYTES), 32'h8000_0000);
    send_entry('0, '0);
    send_header(8'd0, LEN_BITS'(HDR_BYTES + ENTRY_BYTES), 32'd1);  // not listed
    finish_batch();

    // random traffic under six register settings
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < NUM_ORIGINS_MAX; i++) list_now[i] = $urandom;
      case (p)
        0: load_setup(1'b0, 3'd4, ANNOUNCE_TYPE_RESET);
        1: load_setup(1'b1, 3'd2, 8'd0);
        2: begin
          list_now[0] = 32'hFFFF_FFFF;
          list_now[1] = '0;
          load_setup(1'b0, 3'd7, 8'hFF);
        end
        3: load_setup(1'b1, 3'd0, KIND_BITS'($urandom));
        4: load_setup(1'b1, 3'd4, KIND_BITS'($urandom));
        default: load_setup(1'($urandom), COUNT_BITS'($urandom), KIND_BITS'($urandom));
      endcase
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 82;
      end else if (p < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) hold_wanted = 1'b1;  // long back-pressure while requests keep coming
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) send_message();
        else send_noise();
      end
      finish_batch();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
